// ===== sv/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator: operation
// and status codes, configuration register indexes, the queued command and
// the derived pool configuration.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 21;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd2;

    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET    = 21'd64;
    localparam logic [COUNT_W-1:0] BLOCKS_IN_USE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_INDEX_OF = 2'd2,
        OP_ADDR_OF  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_READ,
        BK_MUL,
        BK_ADD,
        BK_DIV,
        BK_RESULT
    } bk_state_t;

    typedef struct packed {
        op_t                kind;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  offset;
        logic [INDEX_W-1:0] index;
        logic               below_base;
        logic               index_bad;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] eff_size;
        logic [ADDR_W-1:0] limit;
    } pool_cfg_t;

endpackage

// ===== sv/fbpa_front.sv =====
// ----------------------------------------------------------------------------
// fbpa_front
// Input side: takes items from the input channel while the pool is ready,
// classifies them against the pool bounds and hands commands to the queue.
// ----------------------------------------------------------------------------
module fbpa_front (
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [fbpa_pkg::ADDR_W-1:0]    s_address,
    input  logic [fbpa_pkg::INDEX_W-1:0]   s_index,
    input  fbpa_pkg::pool_cfg_t            pool_cfg,
    input  logic                           items_enabled,
    output logic                           q_wr_valid,
    input  logic                           q_wr_ready,
    output fbpa_pkg::cmd_t                 q_wr_data
);

    assign s_ready    = q_wr_ready & items_enabled;
    assign q_wr_valid = s_valid & items_enabled;

    always_comb begin
        q_wr_data.kind       = fbpa_pkg::op_t'(s_operation);
        q_wr_data.address    = s_address;
        q_wr_data.offset     = s_address - pool_cfg.base;
        q_wr_data.index      = s_index;
        q_wr_data.below_base = s_address < pool_cfg.base;
        q_wr_data.index_bad  = fbpa_pkg::ADDR_W'(s_index) >= pool_cfg.limit;
    end

endmodule

// ===== sv/fbpa_queue.sv =====
// ----------------------------------------------------------------------------
// fbpa_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module fbpa_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  fbpa_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output fbpa_pkg::cmd_t rd_data
);

    fbpa_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push, pop;

    assign wr_ready = fill_reg != 2'd2;
    assign rd_valid = fill_reg != 2'd0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/fbpa_div.sv =====
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle: 32-bit offset divided by
// the block size. Done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module fbpa_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
    input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
    output logic                          done,
    output logic [fbpa_pkg::ADDR_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(fbpa_pkg::ADDR_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [fbpa_pkg::SIZE_W-1:0]   rem_reg, rem_next;
    logic [fbpa_pkg::SIZE_W-1:0]   div_reg, div_next;
    logic [fbpa_pkg::ADDR_W-1:0]   quo_reg, quo_next;
    logic [fbpa_pkg::SIZE_W:0]     trial;
    logic                          fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        trial     = {rem_reg, quo_reg[fbpa_pkg::ADDR_W-1]};
        fits      = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next  = fits ? fbpa_pkg::SIZE_W'(trial - {1'b0, div_reg})
                             : trial[fbpa_pkg::SIZE_W-1:0];
            quo_next  = {quo_reg[fbpa_pkg::ADDR_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(fbpa_pkg::ADDR_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

endmodule

// ===== sv/fbpa_back.sv =====
// ----------------------------------------------------------------------------
// fbpa_back
// Execution side: free index stack memory, allocation count, address
// multiply, divider control and the result register.
// ----------------------------------------------------------------------------
module fbpa_back #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fbpa_pkg::pool_cfg_t            pool_cfg,
    output logic                           items_enabled,
    input  logic                           q_rd_valid,
    output logic                           q_rd_ready,
    input  fbpa_pkg::cmd_t                 q_rd_data,
    output logic                           div_start,
    output logic [fbpa_pkg::ADDR_W-1:0]    div_dividend,
    input  logic                           div_done,
    input  logic [fbpa_pkg::ADDR_W-1:0]    div_quotient,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fbpa_pkg::ADDR_W-1:0]    m_result_address,
    output logic [fbpa_pkg::INDEX_W-1:0]   m_result_index,
    output logic [2:0]                     m_status,
    output logic [fbpa_pkg::COUNT_W-1:0]   m_allocated_count
);

    localparam int IDXW = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int MULW = (IDXW > fbpa_pkg::INDEX_W) ? IDXW : fbpa_pkg::INDEX_W;
    localparam int PRODW = fbpa_pkg::SIZE_W + MULW;

    fbpa_pkg::bk_state_t           state_reg, state_next;
    logic [IDXW-1:0]               init_ptr_reg, init_ptr_next;
    logic [CNTW-1:0]               count_reg, count_next;
    fbpa_pkg::cmd_t                cmd_reg, cmd_next;
    logic [MULW-1:0]               mul_idx_reg, mul_idx_next;
    logic [PRODW-1:0]              prod_reg, prod_next;
    logic [fbpa_pkg::ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [fbpa_pkg::INDEX_W-1:0]  res_idx_reg, res_idx_next;
    fbpa_pkg::status_t             res_status_reg, res_status_next;
    logic                          out_valid_reg, out_valid_next;
    logic [fbpa_pkg::ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [fbpa_pkg::INDEX_W-1:0]  out_idx_reg, out_idx_next;
    fbpa_pkg::status_t             out_status_reg, out_status_next;
    logic [fbpa_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                          div_armed_reg, div_armed_next;

    logic [IDXW-1:0]               stack_mem [MAX_BLOCKS];
    logic [IDXW-1:0]               rd_data_reg;
    logic [IDXW-1:0]               rd_addr;
    logic                          mem_wr_en;
    logic [IDXW-1:0]               mem_wr_addr;
    logic [IDXW-1:0]               mem_wr_data;

    assign items_enabled     = state_reg != fbpa_pkg::BK_INIT;
    assign div_dividend      = cmd_reg.offset;
    assign div_start         = div_armed_reg;
    assign m_valid           = out_valid_reg;
    assign m_result_address  = out_addr_reg;
    assign m_result_index    = out_idx_reg;
    assign m_status          = out_status_reg;
    assign m_allocated_count = out_count_reg;
    assign rd_addr           = IDXW'(count_reg);

    always_comb begin
        state_next      = state_reg;
        init_ptr_next   = init_ptr_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        mul_idx_next    = mul_idx_reg;
        prod_next       = prod_reg;
        res_addr_next   = res_addr_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        q_rd_ready      = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = init_ptr_reg;
        mem_wr_data     = init_ptr_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fbpa_pkg::BK_INIT: begin
                // clearing pass: entry i holds i
                mem_wr_en = 1'b1;
                if (init_ptr_reg == IDXW'(MAX_BLOCKS - 1)) begin
                    state_next = fbpa_pkg::BK_IDLE;
                end else begin
                    init_ptr_next = init_ptr_reg + IDXW'(1);
                end
            end
            fbpa_pkg::BK_IDLE: begin
                if (q_rd_valid) begin
                    q_rd_ready      = 1'b1;
                    cmd_next        = q_rd_data;
                    res_addr_next   = '0;
                    res_idx_next    = '0;
                    res_status_next = fbpa_pkg::ST_OK;
                    case (q_rd_data.kind)
                        fbpa_pkg::OP_ALLOC: begin
                            if (fbpa_pkg::ADDR_W'(count_reg) >= pool_cfg.limit) begin
                                res_status_next = fbpa_pkg::ST_FULL;
                                state_next      = fbpa_pkg::BK_RESULT;
                            end else begin
                                count_next = count_reg + CNTW'(1);
                                state_next = fbpa_pkg::BK_READ;
                            end
                        end
                        fbpa_pkg::OP_FREE: begin
                            if (count_reg == '0) begin
                                res_status_next = fbpa_pkg::ST_EMPTY;
                                state_next      = fbpa_pkg::BK_RESULT;
                            end else if (q_rd_data.below_base) begin
                                res_status_next = fbpa_pkg::ST_OUTSIDE;
                                state_next      = fbpa_pkg::BK_RESULT;
                            end else begin
                                state_next = fbpa_pkg::BK_DIV;
                            end
                        end
                        fbpa_pkg::OP_INDEX_OF: begin
                            if (q_rd_data.below_base) begin
                                res_status_next = fbpa_pkg::ST_OUTSIDE;
                                state_next      = fbpa_pkg::BK_RESULT;
                            end else begin
                                state_next = fbpa_pkg::BK_DIV;
                            end
                        end
                        fbpa_pkg::OP_ADDR_OF: begin
                            if (q_rd_data.index_bad) begin
                                res_status_next = fbpa_pkg::ST_BAD_INDEX;
                                state_next      = fbpa_pkg::BK_RESULT;
                            end else begin
                                mul_idx_next = MULW'(q_rd_data.index);
                                state_next   = fbpa_pkg::BK_MUL;
                            end
                        end
                        default: begin
                            state_next = fbpa_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            fbpa_pkg::BK_READ: begin
                mul_idx_next = MULW'(rd_data_reg);
                state_next   = fbpa_pkg::BK_MUL;
            end
            fbpa_pkg::BK_MUL: begin
                prod_next  = PRODW'(pool_cfg.eff_size) * PRODW'(mul_idx_reg);
                state_next = fbpa_pkg::BK_ADD;
            end
            fbpa_pkg::BK_ADD: begin
                res_addr_next   = pool_cfg.base + fbpa_pkg::ADDR_W'(prod_reg);
                res_idx_next    = fbpa_pkg::INDEX_W'(mul_idx_reg);
                res_status_next = fbpa_pkg::ST_OK;
                state_next      = fbpa_pkg::BK_RESULT;
            end
            fbpa_pkg::BK_DIV: begin
                // divider is started on entry; its done pulse ends this state
                if (div_done) begin
                    state_next = fbpa_pkg::BK_RESULT;
                    if (div_quotient >= pool_cfg.limit) begin
                        res_status_next = fbpa_pkg::ST_OUTSIDE;
                    end else if (cmd_reg.kind == fbpa_pkg::OP_FREE) begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = IDXW'(count_reg - CNTW'(1));
                        mem_wr_data  = IDXW'(div_quotient);
                        count_next   = count_reg - CNTW'(1);
                        res_idx_next = fbpa_pkg::INDEX_W'(div_quotient);
                    end else begin
                        res_addr_next = cmd_reg.address;
                        res_idx_next  = fbpa_pkg::INDEX_W'(div_quotient);
                    end
                end
            end
            fbpa_pkg::BK_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_idx_next    = res_idx_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = fbpa_pkg::COUNT_W'(count_reg);
                    state_next      = fbpa_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = fbpa_pkg::BK_IDLE;
            end
        endcase
    end

    // divider start is registered together with the command on the move from idle to the divide state
    always_comb begin
        div_armed_next = state_reg == fbpa_pkg::BK_IDLE && state_next == fbpa_pkg::BK_DIV;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fbpa_pkg::BK_INIT;
            init_ptr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            div_armed_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_ptr_reg  <= init_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            div_armed_reg <= div_armed_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        mul_idx_reg    <= mul_idx_next;
        prod_reg       <= prod_next;
        res_addr_reg   <= res_addr_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            stack_mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

endmodule

// ===== sv/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal-sized blocks managed through a stack of free block indices.
// ----------------------------------------------------------------------------
// After reset the block writes every entry of the free index stack (entry i
// holds i) with s_ready low; configuration writes are taken during that
// pass. Allocate runs a stack memory read, a registered multiply and an add;
// address-of-index runs the multiply and the add, without the read. Free and
// index-of-address run the 32-step restoring divider that turns an address
// offset into a block index. An item rejected before the multiply or the
// divider (pool full, nothing allocated, address below the base, index out
// of range) goes straight to the result state. Items are executed one at
// a time in arrival order; a two-entry queue lets the input side keep
// accepting while the execution side works or waits on m_ready.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [fbpa_pkg::ADDR_W-1:0]        s_address,
    input  logic [fbpa_pkg::INDEX_W-1:0]       s_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fbpa_pkg::ADDR_W-1:0]        m_result_address,
    output logic [fbpa_pkg::INDEX_W-1:0]       m_result_index,
    output logic [2:0]                         m_status,
    output logic [fbpa_pkg::COUNT_W-1:0]       m_allocated_count
);

    localparam logic [fbpa_pkg::ADDR_W-1:0] MAX_LIMIT = fbpa_pkg::ADDR_W'(MAX_BLOCKS);

    logic [fbpa_pkg::ADDR_W-1:0]   base_reg;
    logic [fbpa_pkg::SIZE_W-1:0]   size_reg;
    logic [fbpa_pkg::COUNT_W-1:0]  biu_reg;
    fbpa_pkg::pool_cfg_t           pool_cfg;
    logic                          items_enabled;
    logic                          q_wr_valid, q_wr_ready;
    fbpa_pkg::cmd_t                q_wr_data;
    logic                          q_rd_valid, q_rd_ready;
    fbpa_pkg::cmd_t                q_rd_data;
    logic                          div_start, div_done;
    logic [fbpa_pkg::ADDR_W-1:0]   div_dividend, div_quotient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            size_reg <= fbpa_pkg::BLOCK_SIZE_RESET;
            biu_reg  <= fbpa_pkg::BLOCKS_IN_USE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                fbpa_pkg::CFG_BASE_ADDRESS:  base_reg <= cfg_wr_data;
                fbpa_pkg::CFG_BLOCK_SIZE:    size_reg <= fbpa_pkg::SIZE_W'(cfg_wr_data);
                fbpa_pkg::CFG_BLOCKS_IN_USE: biu_reg  <= fbpa_pkg::COUNT_W'(cfg_wr_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        pool_cfg.base     = base_reg;
        pool_cfg.eff_size = (size_reg == '0) ? fbpa_pkg::SIZE_W'(1) : size_reg;
        pool_cfg.limit    = (fbpa_pkg::ADDR_W'(biu_reg) > MAX_LIMIT)
                            ? MAX_LIMIT : fbpa_pkg::ADDR_W'(biu_reg);
    end

    fbpa_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_address     (s_address),
        .s_index       (s_index),
        .pool_cfg      (pool_cfg),
        .items_enabled (items_enabled),
        .q_wr_valid    (q_wr_valid),
        .q_wr_ready    (q_wr_ready),
        .q_wr_data     (q_wr_data)
    );

    fbpa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    fbpa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (pool_cfg.eff_size),
        .done     (div_done),
        .quotient (div_quotient)
    );

    fbpa_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .pool_cfg          (pool_cfg),
        .items_enabled     (items_enabled),
        .q_rd_valid        (q_rd_valid),
        .q_rd_ready        (q_rd_ready),
        .q_rd_data         (q_rd_data),
        .div_start         (div_start),
        .div_dividend      (div_dividend),
        .div_done          (div_done),
        .div_quotient      (div_quotient),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_address  (m_result_address),
        .m_result_index    (m_result_index),
        .m_status          (m_status),
        .m_allocated_count (m_allocated_count)
    );

endmodule

// ===== sv/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks on the result channel of the fixed block pool allocator.
// ----------------------------------------------------------------------------
module fbpa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [fbpa_pkg::ADDR_W-1:0]       m_result_address,
    input logic [fbpa_pkg::INDEX_W-1:0]      m_result_index,
    input logic [2:0]                        m_status,
    input logic [fbpa_pkg::COUNT_W-1:0]      m_allocated_count
);

    a_reset_clears_valid: assert property (
        @(posedge aclk) !aresetn |=> !m_valid
    ) else $error("result valid after reset");

    a_stall_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_address)
            && $stable(m_result_index) && $stable(m_status)
            && $stable(m_allocated_count)
    ) else $error("stalled result changed");

    a_error_zero_payload: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != fbpa_pkg::ST_OK |->
            m_result_address == '0 && m_result_index == '0
    ) else $error("error result carries address or index");

    a_empty_count_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == fbpa_pkg::ST_EMPTY |-> m_allocated_count == '0
    ) else $error("empty status with blocks allocated");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for fixed_block_pool_allocator
// Drives allocate, free and both lookups into the block pool over the
// valid/ready input channel and checks every result against an in-bench
// model of the free index stack, the allocation count and the pool
// configuration. Runs a short directed part, then random phases with
// different pool settings, sender idling, receiver stalls and two long
// receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;

    localparam int POOL_CAPACITY = 1024;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 64;

    typedef struct {
        fbpa_pkg::op_t                op;
        logic [fbpa_pkg::ADDR_W-1:0]  address;
        logic [fbpa_pkg::INDEX_W-1:0] index;
    } pool_req_t;

    typedef struct {
        logic [fbpa_pkg::ADDR_W-1:0]  address;
        logic [fbpa_pkg::INDEX_W-1:0] index;
        fbpa_pkg::status_t            status;
        logic [fbpa_pkg::COUNT_W-1:0] count;
    } pool_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_operation = '0;
    logic [fbpa_pkg::ADDR_W-1:0]     s_address = '0;
    logic [fbpa_pkg::INDEX_W-1:0]    s_index = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [fbpa_pkg::ADDR_W-1:0]     m_result_address;
    logic [fbpa_pkg::INDEX_W-1:0]    m_result_index;
    logic [2:0]                      m_status;
    logic [fbpa_pkg::COUNT_W-1:0]    m_allocated_count;

    // pool model state
    logic [fbpa_pkg::ADDR_W-1:0]  pool_base = '0;
    logic [fbpa_pkg::SIZE_W-1:0]  pool_block_size = fbpa_pkg::BLOCK_SIZE_RESET;
    logic [fbpa_pkg::COUNT_W-1:0] pool_blocks = fbpa_pkg::BLOCKS_IN_USE_RESET;
    logic [fbpa_pkg::INDEX_W-1:0] free_slots [POOL_CAPACITY];
    logic [fbpa_pkg::COUNT_W-1:0] pool_allocated = '0;

    pool_req_t    queued_requests[$];
    pool_result_t awaited_results[$];

    int   fail_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    logic req_taken = 1'b0;

    fixed_block_pool_allocator #(
        .MAX_BLOCKS(POOL_CAPACITY)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_address(s_address),
        .s_index(s_index),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_address(m_result_address),
        .m_result_index(m_result_index),
        .m_status(m_status),
        .m_allocated_count(m_allocated_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [fbpa_pkg::COUNT_W-1:0] pool_limit();
        return (pool_blocks > POOL_CAPACITY) ? fbpa_pkg::COUNT_W'(POOL_CAPACITY)
                                             : pool_blocks;
    endfunction

    function automatic logic [fbpa_pkg::ADDR_W-1:0] pool_unit();
        return (pool_block_size == '0) ? fbpa_pkg::ADDR_W'(1)
                                       : fbpa_pkg::ADDR_W'(pool_block_size);
    endfunction

    function automatic logic [fbpa_pkg::ADDR_W-1:0] block_address(
        input logic [fbpa_pkg::INDEX_W-1:0] idx);
        return pool_base + pool_unit() * fbpa_pkg::ADDR_W'(idx);
    endfunction

    function automatic logic block_index(input logic [fbpa_pkg::ADDR_W-1:0] addr,
                                         output logic [fbpa_pkg::INDEX_W-1:0] idx);
        logic [fbpa_pkg::ADDR_W-1:0] quot;
        idx = '0;
        if (addr < pool_base)
            return 1'b0;
        quot = (addr - pool_base) / pool_unit();
        if (quot >= fbpa_pkg::ADDR_W'(pool_limit()))
            return 1'b0;
        idx = quot[fbpa_pkg::INDEX_W-1:0];
        return 1'b1;
    endfunction

    function automatic pool_result_t apply_pool_op(input pool_req_t req);
        pool_result_t                 res;
        logic [fbpa_pkg::INDEX_W-1:0] idx;
        res.address = '0;
        res.index   = '0;
        res.status  = fbpa_pkg::ST_OK;
        case (req.op)
            fbpa_pkg::OP_ALLOC: begin
                if (pool_allocated >= pool_limit()) begin
                    res.status = fbpa_pkg::ST_FULL;
                end else begin
                    res.index = free_slots[pool_allocated];
                    pool_allocated = pool_allocated + 1'b1;
                    res.address = block_address(res.index);
                end
            end
            fbpa_pkg::OP_FREE: begin
                if (pool_allocated == '0) begin
                    res.status = fbpa_pkg::ST_EMPTY;
                end else if (!block_index(req.address, idx)) begin
                    res.status = fbpa_pkg::ST_OUTSIDE;
                end else begin
                    free_slots[pool_allocated - 1'b1] = idx;
                    pool_allocated = pool_allocated - 1'b1;
                    res.index = idx;
                end
            end
            fbpa_pkg::OP_INDEX_OF: begin
                if (!block_index(req.address, idx)) begin
                    res.status = fbpa_pkg::ST_OUTSIDE;
                end else begin
                    res.index = idx;
                    res.address = req.address;
                end
            end
            default: begin
                if (fbpa_pkg::COUNT_W'(req.index) >= pool_limit()) begin
                    res.status = fbpa_pkg::ST_BAD_INDEX;
                end else begin
                    res.index = req.index;
                    res.address = block_address(req.index);
                end
            end
        endcase
        res.count = pool_allocated;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // driver
    always @(negedge aclk) begin
        pool_req_t req;
        if (aresetn && (!s_valid || req_taken)) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = queued_requests.pop_front();
                s_valid     <= 1'b1;
                s_operation <= req.op;
                s_address   <= req.address;
                s_index     <= req.index;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stalls and long hold-off
    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        pool_req_t    req;
        pool_result_t want;
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            req.op      = fbpa_pkg::op_t'(s_operation);
            req.address = s_address;
            req.index   = s_index;
            awaited_results.push_back(apply_pool_op(req));
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result item with no expected result pending");
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("result_address", want.address, m_result_address);
                check_field("result_index", 32'(want.index), 32'(m_result_index));
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("allocated_count", 32'(want.count), 32'(m_allocated_count));
            end
        end
    end

    task automatic push_op(input fbpa_pkg::op_t op, input logic [fbpa_pkg::ADDR_W-1:0] addr,
                           input logic [fbpa_pkg::INDEX_W-1:0] idx);
        pool_req_t req;
        req.op      = op;
        req.address = addr;
        req.index   = idx;
        queued_requests.push_back(req);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (queued_requests.size() != 0 || s_valid || awaited_results.size() != 0);
    endtask

    task automatic set_pool(input logic [fbpa_pkg::ADDR_W-1:0] base,
                            input logic [31:0] size, input logic [31:0] blocks);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= fbpa_pkg::CFG_BASE_ADDRESS;
        cfg_wr_data  <= base;
        pool_base = base;
        @(negedge aclk);
        cfg_wr_index <= fbpa_pkg::CFG_BLOCK_SIZE;
        cfg_wr_data  <= size;
        pool_block_size = size[fbpa_pkg::SIZE_W-1:0];
        @(negedge aclk);
        cfg_wr_index <= fbpa_pkg::CFG_BLOCKS_IN_USE;
        cfg_wr_data  <= blocks;
        pool_blocks = blocks[fbpa_pkg::COUNT_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random_ops(input int count);
        int                           mode;
        int                           roll;
        int                           alloc_pct;
        int                           free_pct;
        logic [fbpa_pkg::INDEX_W-1:0] idx;
        logic [fbpa_pkg::ADDR_W-1:0]  addr;
        logic [fbpa_pkg::ADDR_W-1:0]  unit;
        fbpa_pkg::op_t                op;
        unit = pool_unit();
        mode = 0;
        for (int k = 0; k < count; k++) begin
            if (k % 16 == 0)
                mode = $urandom_range(2);
            alloc_pct = (mode == 0) ? 60 : (mode == 1) ? 25 : 40;
            free_pct  = (mode == 0) ? 20 : (mode == 1) ? 50 : 25;
            idx  = fbpa_pkg::INDEX_W'($urandom_range(int'(pool_limit()) - 1));
            addr = block_address(idx) + $urandom_range(int'(unit) - 1);
            roll = $urandom_range(99);
            if (roll < 8) begin
                op   = fbpa_pkg::op_t'($urandom_range(3));
                addr = $urandom;
                idx  = fbpa_pkg::INDEX_W'($urandom);
            end else begin
                roll = $urandom_range(99);
                if (roll < alloc_pct)
                    op = fbpa_pkg::OP_ALLOC;
                else if (roll < alloc_pct + free_pct)
                    op = fbpa_pkg::OP_FREE;
                else if (roll < alloc_pct + free_pct + (100 - alloc_pct - free_pct) / 2)
                    op = fbpa_pkg::OP_INDEX_OF;
                else
                    op = fbpa_pkg::OP_ADDR_OF;
            end
            push_op(op, addr, idx);
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_CAPACITY; i++)
            free_slots[i] = fbpa_pkg::INDEX_W'(i);
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: base 0, 64-byte blocks, full capacity
        push_op(fbpa_pkg::OP_FREE, 32'd0, '0);
        push_op(fbpa_pkg::OP_ALLOC, 32'd0, '0);
        push_op(fbpa_pkg::OP_ADDR_OF, 32'd0, 10'd1023);
        push_op(fbpa_pkg::OP_INDEX_OF, 32'd65535, '0);
        push_op(fbpa_pkg::OP_INDEX_OF, 32'd65536, '0);
        push_op(fbpa_pkg::OP_INDEX_OF, 32'hFFFF_FFFF, '0);
        push_op(fbpa_pkg::OP_FREE, 32'd65536, '0);
        push_op(fbpa_pkg::OP_FREE, 32'd63, '0);
        push_op(fbpa_pkg::OP_ALLOC, 32'd0, '0);

        // empty pool
        set_pool(32'd0, 32'd64, 32'd0);
        push_op(fbpa_pkg::OP_ALLOC, 32'd0, '0);
        push_op(fbpa_pkg::OP_ADDR_OF, 32'd0, 10'd0);
        push_op(fbpa_pkg::OP_INDEX_OF, 32'd0, '0);
        push_op(fbpa_pkg::OP_FREE, 32'd0, '0);

        // zero block size, top base, oversized block count, address wrap
        set_pool(32'hFFFF_FFFF, 32'd0, 32'd2047);
        push_op(fbpa_pkg::OP_ALLOC, 32'd0, '0);
        push_op(fbpa_pkg::OP_ADDR_OF, 32'd0, 10'd1023);
        push_op(fbpa_pkg::OP_INDEX_OF, 32'hFFFF_FFFF, '0);
        push_op(fbpa_pkg::OP_INDEX_OF, 32'd5, '0);
        push_op(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF, '0);

        // 1048576-byte blocks, tiny pool filled up
        set_pool(32'd0, 32'd1048576, 32'd4);
        repeat (4) push_op(fbpa_pkg::OP_ALLOC, 32'd0, '0);
        push_op(fbpa_pkg::OP_ADDR_OF, 32'd0, 10'd3);
        push_op(fbpa_pkg::OP_ADDR_OF, 32'd0, 10'd4);
        push_op(fbpa_pkg::OP_INDEX_OF, 32'h0040_0000, '0);
        push_op(fbpa_pkg::OP_FREE, 32'h0030_0005, '0);

        set_pool($urandom & 32'h7FFF_FFFF, $urandom_range(1, 256), 32'd1024);
        queue_random_ops(170);

        set_pool($urandom & 32'h7FFF_FFFF, $urandom_range(1, 1048576), $urandom_range(1, 48));
        send_idle_pct = 62;
        queue_random_ops(170);

        set_pool($urandom & 32'h7FFF_FFFF, $urandom_range(1, 64), $urandom_range(8, 1024));
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        hold_req++;
        queue_random_ops(170);

        set_pool(32'd0, 32'd1048576, 32'd1024);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        queue_random_ops(170);

        set_pool($urandom, 32'd1, $urandom_range(1, 16));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        queue_random_ops(170);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("PASS fixed_block_pool_allocator");
        else
            $display("FAIL fixed_block_pool_allocator");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL fixed_block_pool_allocator");
        $finish;
    end

endmodule
